/* rtl/setd_pkg.sv */
// Shared types, constants and codes for the servo endpoint table driver.
// Depends on nothing; every other file of the block but setd_ram imports it.
package setd_pkg;

  // Table size default and field widths
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CH_W    = 4;
  localparam int ANGLE_W = 8;
  localparam int STEP_W  = 5;
  localparam int PW_W    = 9;
  localparam int SADDR_W = 6;
  localparam int DELAY_W = 16;
  localparam int CFG_W   = 16;
  localparam int SUM_W   = 10;
  localparam int ENTRY_W = 2 * ANGLE_W + 1;

  // Reset values
  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RESET = 8'd20;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET = 8'd160;
  localparam logic [DELAY_W-1:0] OFF_DELAY_RESET = 16'd200;
  localparam logic [ANGLE_W-1:0] LOW_ANGLE_RESET = 8'd85;
  localparam logic [ANGLE_W-1:0] HIGH_ANGLE_RESET = 8'd95;

  // Pulse scale: 204 + angle*204/180 = 204 + (angle*17)/15,
  // (y/15) taken as (y*2185) >> 15, exact for y below 4681
  localparam logic [PW_W-1:0] PW_BASE     = 9'd204;
  localparam int              SCALED_W    = 13;
  localparam logic [11:0]     RECIP_15    = 12'd2185;
  localparam int              RECIP_SHIFT = 15;
  localparam int              PROD_W      = 25;

  // Command codes
  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_code_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_ANGLE = 2'd0,
    REG_MAX_ANGLE = 2'd1,
    REG_OFF_DELAY = 2'd2
  } reg_index_t;

  // Output action codes
  localparam logic ACT_DRIVE = 1'b0;
  localparam logic ACT_OFF   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the beat and issue the table read
    logic pick;   // select endpoint, add step, first clamp
    logic scale;  // second clamp and angle*17
    logic mult;   // reciprocal multiply
    logic emit;   // write back, load drive result
    logic tick;   // advance millisecond count
  } setd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic id_ok;      // turnout_id inside the table
    logic tick_fire;  // count reaches the off delay on this tick
  } setd_stat_t;

endpackage

/* rtl/servo_endpoint_table_driver.sv */
// Top level of the servo endpoint table driver: sequencer plus datapath.
// Depends on setd_pkg, setd_ctrl, setd_datapath and setd_ram.
//
// A command is taken when start is high and busy low. A set or an adjust reads
// the table RAM at acceptance, then passes through a pick-and-clamp step, a
// scale step, a multiply step and a write-back step; busy stays high through
// them, and its result appears with strobe, registered from the write-back
// step. A new command may be given while strobe is high, so commands never
// overlap. A tick passes through a tick step, its switch-off (when the delay is
// reached) on strobe, registered from that step. A set on a channel outside the
// table and the unused command give no result and leave busy low. Each result
// sits on the output ports for the one cycle that strobe is high and cannot be
// held off; the ports keep the last result afterwards. The table comes out of
// reset ready at once, with no clearing pass.
module servo_endpoint_table_driver import setd_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [CH_W-1:0]           turnout_id,
  input  logic                      position_select,
  input  logic signed [STEP_W-1:0]  adjust_step,
  output logic                      strobe,
  output logic                      action,
  output logic [CH_W-1:0]           channel,
  output logic [PW_W-1:0]           pulse_width,
  output logic                      store_write,
  output logic [SADDR_W-1:0]        store_address,
  output logic [ANGLE_W-1:0]        store_value,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  setd_cmd_t  cmd;
  setd_stat_t stat;

  setd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .strobe  (strobe)
  );

  setd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .turnout_id      (turnout_id),
    .position_select (position_select),
    .adjust_step     (adjust_step),
    .action          (action),
    .channel         (channel),
    .pulse_width     (pulse_width),
    .store_write     (store_write),
    .store_address   (store_address),
    .store_value     (store_value)
  );

endmodule

/* rtl/setd_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module setd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/setd_ctrl.sv */
// Sequencer for the servo endpoint table driver.
// Depends on setd_pkg; drives setd_datapath through setd_cmd_t.
module setd_ctrl import setd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  setd_stat_t stat,
  output setd_cmd_t  cmd,
  output logic       busy,
  output logic       strobe
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCALE,
    S_MULT,
    S_EMIT,
    S_TICK
  } state_t;

  state_t state;
  state_t state_next;

  // Pick the path for an accepted beat
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_SET:    state_next = stat.id_ok ? S_READ : S_IDLE;
            CMD_ADJUST: state_next = S_READ;
            CMD_TICK:   state_next = S_TICK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ:  state_next = S_SCALE;
      S_SCALE: state_next = S_MULT;
      S_MULT:  state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      S_TICK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode datapath commands from state
  always_comb begin
    cmd.load  = (state == S_IDLE) && start;
    cmd.pick  = (state == S_READ);
    cmd.scale = (state == S_SCALE);
    cmd.mult  = (state == S_MULT);
    cmd.emit  = (state == S_EMIT);
    cmd.tick  = (state == S_TICK);
  end

  assign busy = (state != S_IDLE);

  // Hold state, raise strobe at the edge that loads a result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_EMIT) || ((state == S_TICK) && stat.tick_fire);
    end
  end

endmodule

/* rtl/setd_datapath.sv */
// Datapath: endpoint table, clamp, pulse scaling, ms counter, result registers.
// Depends on setd_pkg and setd_ram; sequenced by setd_ctrl.
module setd_datapath import setd_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  setd_cmd_t                 cmd,
  output setd_stat_t                stat,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [1:0]                command,
  input  logic [CH_W-1:0]           turnout_id,
  input  logic                      position_select,
  input  logic signed [STEP_W-1:0]  adjust_step,
  output logic                      action,
  output logic [CH_W-1:0]           channel,
  output logic [PW_W-1:0]           pulse_width,
  output logic                      store_write,
  output logic [SADDR_W-1:0]        store_address,
  output logic [ANGLE_W-1:0]        store_value
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [ENTRY_W-1:0] ENTRY_RESET = {1'b0, HIGH_ANGLE_RESET, LOW_ANGLE_RESET};

  // Configuration
  logic [ANGLE_W-1:0] min_angle;
  logic [ANGLE_W-1:0] max_angle;
  logic [DELAY_W-1:0] off_delay_ms;

  // Control state
  logic [CH_W-1:0]    last_channel;
  logic [DELAY_W-1:0] elapsed_ms;
  logic [NUM_CHANNELS-1:0] valid;

  // Beat and working registers
  logic [1:0]                cmd_r;
  logic [CH_W-1:0]           ch_r;
  logic                      sel_r;
  logic signed [STEP_W-1:0]  step_r;
  logic                      valid_q;
  logic                      side_r;
  logic [ANGLE_W-1:0]        lo_r;
  logic [ANGLE_W-1:0]        hi_r;
  logic [ANGLE_W-1:0]        val_r;
  logic [SCALED_W-1:0]       scaled_r;
  logic [PROD_W-1:0]         prod_r;

  // Combinational
  logic [CH_W-1:0]          ch_pick;
  logic [6:0]               ch_ext;
  logic [IDX_W-1:0]         ram_addr;
  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [ENTRY_W-1:0]       entry;
  logic                     side;
  logic [ANGLE_W-1:0]       base;
  logic signed [SUM_W-1:0]  sum;
  logic [ANGLE_W-1:0]       ang;
  logic [PW_W-1:0]          pw;
  logic [DELAY_W-1:0]       elapsed_inc;

  function automatic logic [ANGLE_W-1:0] clamp_angle(
    input logic signed [SUM_W-1:0] v,
    input logic [ANGLE_W-1:0]      lo,
    input logic [ANGLE_W-1:0]      hi
  );
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    lo_s = signed'({2'b00, lo});
    hi_s = signed'({2'b00, hi});
    priority if (v < lo_s) return lo;
    else if (v > hi_s)     return hi;
    else                   return v[ANGLE_W-1:0];
  endfunction

  // Channel check and tick decision
  assign stat.id_ok = ({3'b000, turnout_id} < 7'(NUM_CHANNELS));
  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 16'd1;
  assign stat.tick_fire = (elapsed_inc >= off_delay_ms);

  // Table address: turnout_id for a set on load, last channel for other loads, held channel otherwise
  assign ch_pick  = (cmd.load && (command == CMD_SET)) ? turnout_id :
                    (cmd.load ? last_channel : ch_r);
  assign ch_ext   = 7'(ch_pick);
  assign ram_addr = ch_ext[IDX_W-1:0];
  assign ram_we   = cmd.emit;
  assign ram_wdata = side_r ? {side_r, val_r, lo_r} : {side_r, hi_r, val_r};

  setd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.load),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Entry not yet written reads as its reset value
  assign entry = valid_q ? ram_rdata : ENTRY_RESET;
  assign side  = (cmd_r == CMD_SET) ? sel_r : entry[ENTRY_W-1];
  assign base  = side ? entry[2*ANGLE_W-1:ANGLE_W] : entry[ANGLE_W-1:0];
  assign sum   = signed'({2'b00, base}) + SUM_W'(step_r);
  assign ang   = clamp_angle(signed'({2'b00, val_r}), min_angle, max_angle);
  assign pw    = PW_BASE + PW_W'(prod_r[PROD_W-1:RECIP_SHIFT]);

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle    <= MIN_ANGLE_RESET;
      max_angle    <= MAX_ANGLE_RESET;
      off_delay_ms <= OFF_DELAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_ANGLE: min_angle    <= cfg_data[ANGLE_W-1:0];
        REG_MAX_ANGLE: max_angle    <= cfg_data[ANGLE_W-1:0];
        REG_OFF_DELAY: off_delay_ms <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits, last channel and millisecond count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      last_channel <= '0;
      elapsed_ms   <= '0;
    end else begin
      if (cmd.emit) begin
        valid[ram_addr] <= 1'b1;
        last_channel    <= ch_r;
        elapsed_ms      <= '0;
      end else if (cmd.tick) begin
        elapsed_ms <= stat.tick_fire ? '0 : elapsed_inc;
      end
    end
  end

  // Working registers along the drive path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= command;
      ch_r    <= ch_pick;
      sel_r   <= position_select;
      step_r  <= adjust_step;
      valid_q <= valid[ram_addr];
    end
    if (cmd.pick) begin
      side_r <= side;
      lo_r   <= entry[ANGLE_W-1:0];
      hi_r   <= entry[2*ANGLE_W-1:ANGLE_W];
      val_r  <= (cmd_r == CMD_ADJUST) ? clamp_angle(sum, min_angle, max_angle) : base;
    end
    if (cmd.scale) begin
      scaled_r <= {1'b0, ang, 4'b0000} + SCALED_W'(ang);
    end
    if (cmd.mult) begin
      prod_r <= PROD_W'(scaled_r) * PROD_W'(RECIP_15);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      action        <= ACT_DRIVE;
      channel       <= ch_r;
      pulse_width   <= pw;
      store_write   <= (cmd_r == CMD_ADJUST);
      store_address <= (cmd_r == CMD_ADJUST) ? {1'b0, ch_r, side_r} + 6'd1 : '0;
      store_value   <= (cmd_r == CMD_ADJUST) ? val_r : '0;
    end else if (cmd.tick && stat.tick_fire) begin
      action        <= ACT_OFF;
      channel       <= last_channel;
      pulse_width   <= '0;
      store_write   <= 1'b0;
      store_address <= '0;
      store_value   <= '0;
    end
  end

endmodule

/* rtl/setd_checker.sv */
// Port-level checks for the servo endpoint table driver, bound to the top level.
// Depends on setd_pkg and servo_endpoint_table_driver.
module setd_checker import setd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                command,
  input logic                      strobe,
  input logic                      action,
  input logic [CH_W-1:0]           channel,
  input logic [PW_W-1:0]           pulse_width,
  input logic                      store_write,
  input logic [SADDR_W-1:0]        store_address,
  input logic [ANGLE_W-1:0]        store_value
);

  // A switch-off beat carries no pulse and no store write
  a_off_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && (action == ACT_OFF) |-> (pulse_width == '0) && !store_write)
    else $error("switch-off beat with pulse or store write");

  // A drive beat never goes below the base pulse width
  a_drive_min: assert property (@(posedge clk) disable iff (rst)
    strobe && (action == ACT_DRIVE) |-> (pulse_width >= PW_BASE))
    else $error("drive pulse below base width");

  // Store address follows the driven channel
  a_store_addr: assert property (@(posedge clk) disable iff (rst)
    strobe && store_write |-> (action == ACT_DRIVE) &&
      ((store_address == {1'b0, channel, 1'b0} + 6'd1) ||
       (store_address == {1'b0, channel, 1'b0} + 6'd2)))
    else $error("store address does not match channel");

  // Results never come in consecutive cycles
  a_no_back: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results in consecutive cycles");

  // An accepted adjust always occupies the block
  a_adjust_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == CMD_ADJUST) |=> busy)
    else $error("adjust accepted without going busy");

endmodule

bind servo_endpoint_table_driver setd_checker u_setd_checker (.*);
